>>> src/lfo_pkg.sv
// ----------------------------------------------------------------------------
// LFO and ramp controller package
// Shared types, constants, the sine table generator and divide-by-125 helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lfo_pkg;

  localparam int unsigned ChannelsDef = 4;
  localparam int unsigned LfoChannelsDef = 2;
  localparam int unsigned SineDepthDef = 1024;

  localparam logic [16:0] Turn = 17'd64000;
  localparam logic [19:0] PhaseMax = 20'hFFFFF;
  localparam logic [15:0] DebounceReset = 16'd200;
  localparam logic [6:0] AmpReset = 7'd63;
  localparam logic [6:0] RateReset = 7'd63;
  localparam logic [7:0] SentReset = 8'd255;

  // One turn is 512 * 125 units. Division by 125 of a value below 2^23 is
  // exact with this reciprocal and a shift by 30.
  localparam logic [23:0] Recip125 = 24'd8589935;

  typedef enum logic [1:0] {
    OP_PRESS = 2'd0,
    OP_AMP   = 2'd1,
    OP_RATE  = 2'd2,
    OP_POLL  = 2'd3
  } op_t;

  // One entry of the channel state memory.
  typedef struct packed {
    logic        active;
    logic [31:0] stamp;
    logic [19:0] phase;
    logic [6:0]  amplitude;
    logic [6:0]  rate;
    logic [7:0]  sent;
  } chan_t;

  localparam int unsigned ChanW = $bits(chan_t);

  function automatic logic [16:0] div125(input logic [22:0] x);
    logic [46:0] p;
    p = 47'(x) * 47'(Recip125);
    return p[46:30];
  endfunction

  function automatic logic [6:0] rem125(input logic [22:0] x, input logic [16:0] q);
    logic [22:0] back;
    back = 23'(q) * 23'd125;
    return 7'(x - back);
  endfunction

  function automatic logic signed [16:0] sine_q15(input int unsigned k, input int unsigned depth);
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] mag;
    logic [1:0] quad;
    int unsigned n;
    t = (64'(k) << 32) / 64'(depth);
    quad = t[31:30];
    r = {34'd0, t[29:0]};
    if (quad[0]) begin
      r = 64'h40000000 - r;
    end
    x = (r * 64'd1686629713) >> 30;
    sum = $signed(x);
    term = x;
    for (n = 1; n <= 5; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    mag = (64'(sum) * 64'd32767 + 64'h20000000) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return quad[1] ? -$signed({1'b0, mag[15:0]}) : $signed({1'b0, mag[15:0]});
  endfunction

endpackage

`default_nettype wire

>>> src/lfo_ramp_cc_generator.sv
// ----------------------------------------------------------------------------
// LFO and ramp controller generator
// Sine LFO and one-shot ramp channels that produce controller values.
// ----------------------------------------------------------------------------
// Each item is taken when start is high and busy is low. Press, amplitude and
// rate items keep busy high through a read of the channel memory, a wait for
// its data and a write back. A poll walks the channels one after another
// through the same memory; each channel goes through a read, a wait, a
// multiply, reduction of the elapsed time, phase sum, the phase wrap, the
// table index, table read, scale and write back, because every reduction
// modulo one turn is a multiply by a reciprocal followed by a subtract. Busy
// stays high until the last channel is written back and the last result
// appears as busy goes low; each result is valid for one cycle under strobe.
// After reset the block runs a clearing pass over every entry of the channel
// memory with busy high. Results cannot be stalled.
`default_nettype none

module lfo_ramp_cc_generator
  import lfo_pkg::*;
#(
  parameter int unsigned CHANNELS = ChannelsDef,
  parameter int unsigned LFO_CHANNELS = LfoChannelsDef,
  parameter int unsigned SINE_TABLE_DEPTH = SineDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic [1:0]  op,
  input  wire logic [1:0]  channel,
  input  wire logic [6:0]  value,
  input  wire logic [31:0] now_ms,
  output logic             strobe,
  output logic [1:0]       out_channel,
  output logic [6:0]       cc_value,
  output logic             changed,
  output logic             last
);

  localparam int unsigned CW = $clog2(CHANNELS);
  localparam int unsigned KW = $clog2(SINE_TABLE_DEPTH);

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_READ  = 14'b00000000000100,
    S_WAIT  = 14'b00000000001000,
    S_MUL   = 14'b00000000010000,
    S_MOD   = 14'b00000000100000,
    S_IDX   = 14'b00000001000000,
    S_WRAP  = 14'b00000010000000,
    S_PHASE = 14'b00000100000000,
    S_KIDX  = 14'b00001000000000,
    S_SINE  = 14'b00010000000000,
    S_ROM   = 14'b00100000000000,
    S_SCALE = 14'b01000000000000,
    S_WRITE = 14'b10000000000000
  } state_t;

  state_t state;
  logic [15:0] debounce;
  logic [CW-1:0] selected;
  logic [31:0] last_toggle;
  logic [CW:0] idx;
  op_t cur_op;
  logic [1:0] cur_ch;
  logic [6:0] cur_val;
  logic [31:0] cur_now;
  chan_t ent;
  logic [38:0] step;
  logic [39:0] sum;
  logic [19:0] ph;
  logic [16:0] quo;
  logic [15:0] red;
  logic [22:0] lsum;
  logic [22:0] num;
  logic signed [16:0] sine;
  logic signed [23:0] prod;
  logic [6:0] cc;
  logic stop;

  logic ram_we;
  logic [CW-1:0] ram_waddr;
  logic [CW-1:0] ram_raddr;
  chan_t ram_wdata;
  logic [ChanW-1:0] ram_rdata;

  logic [CW-1:0] ch_idx;
  assign ch_idx = idx[CW-1:0];

  logic is_lfo;
  assign is_lfo = (idx < (CW+1)'(LFO_CHANNELS));

  logic [31:0] dt;
  assign dt = cur_now - ent.stamp;

  logic signed [23:0] half_amp;
  logic signed [23:0] sine_wide;
  assign half_amp = {18'd0, ent.amplitude[6:1]};
  assign sine_wide = {{7{sine[16]}}, sine};

  lfo_ram #(.Width(ChanW), .Depth(CHANNELS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [16:0] sine_rom [SINE_TABLE_DEPTH];
  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    assign sine_rom[g] = sine_q15(g, SINE_TABLE_DEPTH);
  end

  logic [CW-1:0] target;
  always_comb begin
    case (cur_op)
      OP_PRESS: target = CW'(cur_ch);
      OP_POLL:  target = ch_idx;
      default:  target = selected;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign ram_raddr = target;
  assign ram_waddr = (state == S_CLEAR) ? ch_idx : target;

  logic [31:0] since;
  assign since = cur_now - last_toggle;
  logic press_ok;
  assign press_ok = ({30'd0, cur_ch} < 32'(CHANNELS)) && (since > {16'd0, debounce});

  always_comb begin
    ram_we = 1'b0;
    ram_wdata = ent;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
      ram_wdata = '{active: 1'b0, stamp: 32'd0, phase: 20'd0, amplitude: AmpReset,
                    rate: RateReset, sent: SentReset};
    end else if (state == S_WRITE) begin
      ram_we = (cur_op != OP_PRESS) || press_ok;
      case (cur_op)
        OP_PRESS: begin
          ram_wdata.active = !ent.active;
          ram_wdata.stamp = ent.active ? 32'd0 : cur_now;
          ram_wdata.phase = 20'd0;
        end
        OP_AMP: ram_wdata.amplitude = cur_val;
        OP_RATE: begin
          ram_wdata.rate = cur_val;
          if (cur_val == 7'd0) begin
            ram_wdata.phase = 20'd0;
          end
        end
        default: begin
          if (ent.active) begin
            ram_wdata.stamp = cur_now;
            ram_wdata.phase = ph;
            if (stop) begin
              ram_wdata.active = 1'b0;
            end
            if ({1'b0, cc} != ent.sent) begin
              ram_wdata.sent = {1'b0, cc};
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      debounce <= DebounceReset;
      selected <= '0;
      last_toggle <= '0;
      idx <= '0;
      strobe <= 1'b0;
      cur_op <= OP_PRESS;
    end else begin
      strobe <= 1'b0;
      if (cfg_we) begin
        debounce <= cfg_wdata;
      end
      case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == (CW+1)'(CHANNELS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cur_op <= op_t'(op);
            cur_ch <= channel;
            cur_val <= value;
            cur_now <= now_ms;
            idx <= '0;
            state <= S_READ;
          end
        end
        S_READ: state <= S_WAIT;
        S_WAIT: begin
          ent <= chan_t'(ram_rdata);
          state <= (cur_op == OP_POLL) ? S_MUL : S_WRITE;
        end
        S_MUL: begin
          step <= 39'(cur_now - ent.stamp) * 39'(ent.rate);
          quo <= div125(dt[31:9]);
          state <= S_MOD;
        end
        S_MOD: begin
          sum <= 40'(ent.phase) + 40'(step);
          red <= {rem125(dt[31:9], quo), dt[8:0]};
          state <= S_IDX;
        end
        S_IDX: begin
          // The LFO works on the elapsed time reduced modulo one turn.
          stop <= 1'b0;
          if (is_lfo) begin
            lsum <= 23'(ent.phase) + 23'(red) * 23'(ent.rate);
          end else begin
            ph <= (sum > 40'(PhaseMax)) ? PhaseMax : sum[19:0];
            stop <= (sum >= 40'(Turn));
          end
          state <= S_WRAP;
        end
        S_WRAP: begin
          if (is_lfo) begin
            quo <= div125(23'(lsum[22:9]));
          end else begin
            num <= 23'((27'(ent.amplitude) * 27'(ph)) >> 9);
          end
          state <= S_PHASE;
        end
        S_PHASE: begin
          if (is_lfo) begin
            ph <= {4'd0, rem125(23'(lsum[22:9]), quo), lsum[8:0]};
          end else begin
            quo <= div125(num);
          end
          state <= S_KIDX;
        end
        S_KIDX: begin
          if (is_lfo) begin
            num <= 23'((29'(ph[15:0]) * 29'(SINE_TABLE_DEPTH)) >> 9);
          end
          state <= S_SINE;
        end
        S_SINE: begin
          if (is_lfo) begin
            quo <= div125(num);
          end
          state <= S_ROM;
        end
        S_ROM: begin
          sine <= $signed(sine_rom[KW'(quo)]);
          state <= S_SCALE;
        end
        S_SCALE: begin
          if (is_lfo) begin
            prod <= half_amp * sine_wide;
          end else begin
            prod <= 24'(quo);
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (cur_op == OP_PRESS && press_ok) begin
            last_toggle <= cur_now;
            selected <= CW'(cur_ch);
          end
          if (cur_op == OP_POLL) begin
            strobe <= 1'b1;
            out_channel <= 2'(ch_idx);
            changed <= ent.active && ({1'b0, cc} != ent.sent);
            cc_value <= (ent.active && ({1'b0, cc} != ent.sent)) ? cc : 7'd0;
            last <= (idx == (CW+1)'(CHANNELS - 1));
            if (idx == (CW+1)'(CHANNELS - 1)) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
              state <= S_READ;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic [24:0] lfo_acc;
  assign lfo_acc = 25'(24'sd2064384 + prod);
  always_comb begin
    if (is_lfo) begin
      cc = lfo_acc[21:15];
    end else begin
      cc = (prod > 24'sd127) ? 7'd127 : prod[6:0];
    end
  end

  assert property (@(posedge clk) disable iff (rst) strobe |-> $past(state) == S_WRITE)
    else $error("result without write back");
  assert property (@(posedge clk) disable iff (rst) ram_we |-> state != S_IDLE)
    else $error("memory write while idle");
  assert property (@(posedge clk) disable iff (rst) (strobe && last) |-> state == S_IDLE)
    else $error("poll did not finish");

endmodule

`default_nettype wire

>>> src/lfo_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
